FILE: src/mavg_pkg.sv
// Shared types and constants for the moving average with gain block.
`timescale 1ns / 1ps
`default_nettype none

package mavg_pkg;

  // Fixed field widths
  localparam int WL_W   = 7;   // window_length register
  localparam int GAIN_W = 16;  // gain register, signed Q8.8
  localparam int DATA_W = 16;  // configuration write data
  localparam int OUT_W  = 24;  // smoothed result
  localparam int IDX_W  = 1;   // configuration register index

  // Result clipping limits
  localparam int OUT_MAX     = 8388607;
  localparam int OUT_MIN_MAG = 8388608;

  // Register reset values
  localparam int WL_RESET   = 1;
  localparam int GAIN_RESET = 256;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [IDX_W-1:0] REG_GAIN          = 1'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP_CHK,
    ST_DROP_SUB,
    ST_WRITE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } mavg_state_t;

endpackage

`default_nettype wire

FILE: src/moving_average_with_gain_unit.sv
// Moving average with gain: ring buffer, running sum, multiply and iterative divide.
// Per accepted sample it drops the oldest held samples while the window is full,
//   writes the new sample, multiplies the running sum by the gain and runs a restoring
//   divider that produces one quotient bit a cycle, dividing by the number of held samples.
// The sample channel stalls while an item is in work; a finished result waits in the
//   output register while the next sample is taken.
// Reset (rst, synchronous): window empty, window_length = 1, gain = 1.0, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module moving_average_with_gain_unit #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst,
  // configuration write port
  input  wire                               write_enable,
  input  wire  [mavg_pkg::IDX_W-1:0]        register_index,
  input  wire  [mavg_pkg::DATA_W-1:0]       write_data,
  // sample channel
  input  wire                               sample_valid,
  output logic                              sample_stall,
  input  wire  signed [SAMPLE_BITS-1:0]     sample,
  input  wire                               restart,
  // result channel
  output logic                              result_valid,
  input  wire                               result_stall,
  output logic signed [mavg_pkg::OUT_W-1:0] smoothed,
  output logic                              saturated
);

  import mavg_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_MAX + 1);
  localparam int SLOT_W = $clog2(WINDOW_MAX);
  localparam int OLD_W  = $clog2(2 * WINDOW_MAX);
  localparam int SUM_W  = SAMPLE_BITS + FILL_W;
  localparam int P_W    = SUM_W + GAIN_W;
  localparam int D_W    = P_W + 1;
  localparam int Q_W    = SAMPLE_BITS + 7;
  localparam int R_W    = FILL_W + 9;
  localparam int CNT_W  = $clog2(Q_W);
  localparam int CW     = (FILL_W > WL_W) ? FILL_W : WL_W;
  localparam int CMP_W  = (Q_W > OUT_W + 1) ? Q_W : OUT_W + 1;

  // Configuration registers
  logic [WL_W-1:0]          window_length;
  logic signed [GAIN_W-1:0] gain;

  // Sequencer and datapath registers
  mavg_state_t              state, state_next;
  logic signed [SAMPLE_BITS-1:0] sample_reg;
  logic signed [SAMPLE_BITS-1:0] hist_rdata;
  logic signed [SUM_W-1:0]  running_sum;
  logic [FILL_W-1:0]        fill_count;
  logic [SLOT_W-1:0]        write_slot;
  logic signed [P_W-1:0]    prod;
  logic                     neg;
  logic [R_W-1:0]           rem;
  logic [Q_W-1:0]           quo;
  logic [CNT_W-1:0]         div_count;

  // Sample history ring
  logic [SAMPLE_BITS-1:0]   hist [WINDOW_MAX];

  // Combinational helpers
  logic                     accept;
  logic                     out_free;
  logic [CW-1:0]            wl_ext;
  logic [CW-1:0]            win_c;
  logic [FILL_W-1:0]        win;
  logic                     need_drop;
  logic [OLD_W-1:0]         old_raw;
  logic [OLD_W-1:0]         old_mod;
  logic [SLOT_W-1:0]        oldest;
  logic signed [SUM_W-1:0]  addend;
  logic [P_W-1:0]           mag;
  logic [D_W-1:0]           dividend;
  logic [R_W-1:0]           den;
  logic [R_W-1:0]           trial;
  logic                     trial_ge;
  logic [CMP_W-1:0]         q_ext;
  logic [CMP_W-1:0]         q_clip;
  logic [CMP_W-1:0]         q_signed;
  logic                     clip;

  assign accept   = sample_valid && !sample_stall;
  assign out_free = !result_valid || !result_stall;

  // Clamp the window length into 1..WINDOW_MAX
  always_comb begin
    wl_ext = CW'(window_length);
    if (wl_ext == '0) begin
      win_c = CW'(1);
    end else if (wl_ext > CW'(WINDOW_MAX)) begin
      win_c = CW'(WINDOW_MAX);
    end else begin
      win_c = wl_ext;
    end
    win = FILL_W'(win_c);
  end

  assign need_drop = (fill_count >= win) && (fill_count != '0);

  // Locate the oldest held sample: write_slot - fill_count, modulo the ring depth
  always_comb begin
    old_raw = OLD_W'(write_slot) + OLD_W'(WINDOW_MAX) - OLD_W'(fill_count);
    old_mod = (old_raw >= OLD_W'(WINDOW_MAX)) ? old_raw - OLD_W'(WINDOW_MAX) : old_raw;
    oldest  = old_mod[SLOT_W-1:0];
  end

  // Shared adder operand: subtract the oldest sample or add the new one
  assign addend = (state == ST_DROP_SUB) ? -SUM_W'(hist_rdata) : SUM_W'(sample_reg);

  // Magnitude of the product plus half the divisor for rounding
  always_comb begin
    mag      = prod[P_W-1] ? (~P_W'(prod) + P_W'(1)) : P_W'(prod);
    dividend = {1'b0, mag} + D_W'({fill_count, 7'b0});
  end

  // One restoring divide step
  always_comb begin
    den      = R_W'({fill_count, 8'b0});
    trial    = {rem[R_W-2:0], quo[Q_W-1]};
    trial_ge = (trial >= den);
  end

  // Clip and apply the sign
  always_comb begin
    q_ext = CMP_W'(quo);
    clip  = 1'b0;
    q_clip = q_ext;
    if (!neg && (q_ext > CMP_W'(OUT_MAX))) begin
      q_clip = CMP_W'(OUT_MAX);
      clip   = 1'b1;
    end else if (neg && (q_ext > CMP_W'(OUT_MIN_MAG))) begin
      q_clip = CMP_W'(OUT_MIN_MAG);
      clip   = 1'b1;
    end
    q_signed = neg ? (~q_clip + CMP_W'(1)) : q_clip;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WL_W'(WL_RESET);
      gain          <= GAIN_W'(GAIN_RESET);
    end else if (write_enable) begin
      if (register_index == REG_WINDOW_LENGTH) begin
        window_length <= write_data[WL_W-1:0];
      end
      if (register_index == REG_GAIN) begin
        gain <= write_data[GAIN_W-1:0];
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and channel stall
  always_comb begin
    state_next   = state;
    sample_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_DROP_CHK;
      end
      ST_DROP_CHK: begin
        state_next = need_drop ? ST_DROP_SUB : ST_WRITE;
      end
      ST_DROP_SUB: state_next = ST_DROP_CHK;
      ST_WRITE:    state_next = ST_MUL;
      ST_MUL:      state_next = ST_PREP;
      ST_PREP:     state_next = ST_DIV;
      ST_DIV: begin
        if (div_count == '0) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Window state: running sum, fill count, write slot
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      fill_count  <= '0;
      write_slot  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && restart) begin
            running_sum <= '0;
            fill_count  <= '0;
            write_slot  <= '0;
          end
        end
        ST_DROP_SUB: begin
          running_sum <= running_sum + addend;
          fill_count  <= fill_count - FILL_W'(1);
        end
        ST_WRITE: begin
          running_sum <= running_sum + addend;
          fill_count  <= fill_count + FILL_W'(1);
          write_slot  <= (write_slot == SLOT_W'(WINDOW_MAX - 1)) ?
                         '0 : write_slot + SLOT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // History ring: write the new sample, read the oldest one
  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      hist[write_slot] <= sample_reg;
    end
    if (state == ST_DROP_CHK) begin
      hist_rdata <= hist[oldest];
    end
  end

  // Product, divider and sample holding registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) sample_reg <= sample;
      end
      ST_MUL: begin
        prod <= running_sum * gain;
      end
      ST_PREP: begin
        neg       <= prod[P_W-1];
        rem       <= dividend[Q_W +: R_W];
        quo       <= dividend[Q_W-1:0];
        div_count <= CNT_W'(Q_W - 1);
      end
      ST_DIV: begin
        rem       <= trial_ge ? trial - den : trial;
        quo       <= {quo[Q_W-2:0], trial_ge};
        div_count <= div_count - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Output register: hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      smoothed  <= q_signed[OUT_W-1:0];
      saturated <= clip;
    end
  end

  // Checks on the sequencer and window bookkeeping
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(WINDOW_MAX))
    else $error("fill count exceeds ring depth");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && restart) |=> (fill_count == '0 && running_sum == '0 && write_slot == '0))
    else $error("restart did not empty the window");

  a_write_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |=> (fill_count == $past(fill_count) + FILL_W'(1) &&
                             fill_count <= win))
    else $error("window overfilled after sample write");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_count == '0) |=> (state == ST_DONE))
    else $error("divider did not finish on its last step");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (result_valid && saturated) |->
      (smoothed == OUT_W'(OUT_MAX) || smoothed == OUT_W'(OUT_MIN_MAG)))
    else $error("clipped result is not a limit value");

endmodule

`default_nettype wire
